FILE: hw/rtl/ook48_pkg.sv
package ook48_pkg;

    // Field and state widths
    localparam int unsigned CharW  = 8;
    localparam int unsigned SymW   = 8;
    localparam int unsigned IdxW   = 7;
    localparam int unsigned PhaseW = 10;
    localparam int unsigned SlotW  = 4;
    localparam int unsigned AdvW   = 10;
    localparam int unsigned SumW   = 11;

    // Request kinds carried on tuser
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_opcode;

    // Timing constants
    localparam logic [AdvW-1:0]   AdvanceReset = 10'd225;
    localparam logic [PhaseW-1:0] SecondLast   = 10'd999;
    localparam logic [SumW-1:0]   SecondMs     = 11'd1000;
    localparam logic [SumW-1:0]   SlotMs       = 11'd111;
    localparam logic [SlotW-1:0]  LastSlot     = 4'd8;

    // Character index constants
    localparam logic [IdxW-1:0]  NullIndex  = 7'd69;
    localparam logic [IdxW-1:0]  CrLfIndex  = 7'd0;
    localparam logic [CharW-1:0] CharLf     = 8'd10;
    localparam logic [CharW-1:0] CharCr     = 8'd13;
    localparam logic [CharW-1:0] UpperFirst = 8'd32;
    localparam logic [CharW-1:0] UpperLast  = 8'd95;
    localparam logic [CharW-1:0] UpperBias  = 8'd31;
    localparam logic [CharW-1:0] LowerFirst = 8'd97;
    localparam logic [CharW-1:0] LowerLast  = 8'd122;
    localparam logic [CharW-1:0] LowerBias  = 8'd63;

    // All bytes with exactly four bits set, ascending
    localparam int unsigned SymCount = 70;
    localparam logic [SymW-1:0] SymTable [SymCount] = '{
        8'd15,  8'd23,  8'd27,  8'd29,  8'd30,  8'd39,  8'd43,  8'd45,  8'd46,  8'd51,
        8'd53,  8'd54,  8'd57,  8'd58,  8'd60,  8'd71,  8'd75,  8'd77,  8'd78,  8'd83,
        8'd85,  8'd86,  8'd89,  8'd90,  8'd92,  8'd99,  8'd101, 8'd102, 8'd105, 8'd106,
        8'd108, 8'd113, 8'd114, 8'd116, 8'd120, 8'd135, 8'd139, 8'd141, 8'd142, 8'd147,
        8'd149, 8'd150, 8'd153, 8'd154, 8'd156, 8'd163, 8'd165, 8'd166, 8'd169, 8'd170,
        8'd172, 8'd177, 8'd178, 8'd180, 8'd184, 8'd195, 8'd197, 8'd198, 8'd201, 8'd202,
        8'd204, 8'd209, 8'd210, 8'd212, 8'd216, 8'd225, 8'd226, 8'd228, 8'd232, 8'd240
    };

    // Step control from the input register to the keyer core
    typedef struct packed {
        logic    valid;
        t_opcode opcode;
    } t_step_ctl;

    // One result item
    typedef struct packed {
        logic             char_taken;
        logic [SlotW-1:0] slot_number;
        logic             slot_start;
        logic             key_on;
    } t_result;

endpackage

FILE: hw/rtl/ook48_char_map.sv
module ook48_char_map (
    input  logic [ook48_pkg::CharW-1:0] i_char_code,
    output logic [ook48_pkg::SymW-1:0]  o_symbol
);

    logic [ook48_pkg::CharW-1:0] upper_off;
    logic [ook48_pkg::CharW-1:0] lower_off;
    logic [ook48_pkg::IdxW-1:0]  sym_idx;

    assign upper_off = i_char_code - ook48_pkg::UpperBias;
    assign lower_off = i_char_code - ook48_pkg::LowerBias;

    // Classify the character into a table index
    always_comb begin
        if (i_char_code == ook48_pkg::CharLf || i_char_code == ook48_pkg::CharCr) begin
            sym_idx = ook48_pkg::CrLfIndex;
        end else if (i_char_code >= ook48_pkg::UpperFirst &&
                     i_char_code <= ook48_pkg::UpperLast) begin
            sym_idx = upper_off[ook48_pkg::IdxW-1:0];
        end else if (i_char_code >= ook48_pkg::LowerFirst &&
                     i_char_code <= ook48_pkg::LowerLast) begin
            sym_idx = lower_off[ook48_pkg::IdxW-1:0];
        end else begin
            sym_idx = ook48_pkg::NullIndex;
        end
    end

    // Look up the 4-of-8 symbol
    assign o_symbol = ook48_pkg::SymTable[sym_idx];

endmodule

FILE: hw/rtl/ook48_keyer_core.sv
module ook48_keyer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ook48_pkg::AdvW-1:0] i_cfg_wr_data,
    input  ook48_pkg::t_step_ctl       i_step,
    input  logic [ook48_pkg::SymW-1:0] i_symbol,
    output ook48_pkg::t_result         o_result
);

    logic [ook48_pkg::AdvW-1:0]   r_advance;
    logic [ook48_pkg::PhaseW-1:0] r_phase,   n_phase;
    logic                         r_sending, n_sending;
    logic [ook48_pkg::SlotW-1:0]  r_slot,    n_slot;
    logic [ook48_pkg::PhaseW-1:0] r_elapsed, n_elapsed;
    logic [ook48_pkg::SymW-1:0]   r_shift,   n_shift;
    logic                         r_pend_valid, n_pend_valid;
    logic [ook48_pkg::SymW-1:0]   r_pend_sym,   n_pend_sym;
    logic                         r_key,     n_key;
    logic                         started;
    logic                         taken;

    logic [ook48_pkg::PhaseW-1:0] phase_inc;
    logic [ook48_pkg::PhaseW-1:0] elapsed_inc;
    logic [ook48_pkg::AdvW-1:0]   adv_mod;
    logic [ook48_pkg::SumW-1:0]   bound_sum;
    logic                         at_boundary;
    logic [ook48_pkg::SumW-1:0]   slot_end;
    logic [ook48_pkg::SlotW-1:0]  slot_inc;

    // Phase, advance and slot timing terms
    assign phase_inc   = (r_phase == ook48_pkg::SecondLast) ? '0 : r_phase + 1'b1;
    assign elapsed_inc = r_elapsed + 1'b1;
    assign adv_mod     = ({1'b0, r_advance} >= ook48_pkg::SecondMs)
                         ? ook48_pkg::AdvW'({1'b0, r_advance} - ook48_pkg::SecondMs)
                         : r_advance;
    assign bound_sum   = {1'b0, phase_inc} + {1'b0, adv_mod};
    assign at_boundary = (bound_sum == '0) || (bound_sum == ook48_pkg::SecondMs);
    assign slot_inc    = r_slot + 1'b1;
    assign slot_end    = ook48_pkg::SlotMs *
                         ({{(ook48_pkg::SumW-ook48_pkg::SlotW){1'b0}}, r_slot} + 1'b1);

    // Next state for one request
    always_comb begin
        n_phase      = r_phase;
        n_sending    = r_sending;
        n_slot       = r_slot;
        n_elapsed    = r_elapsed;
        n_shift      = r_shift;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_key        = r_key;
        started      = 1'b0;
        taken        = 1'b0;
        case (i_step.opcode)
            ook48_pkg::OP_LOAD: begin
                n_pend_sym   = i_symbol;
                n_pend_valid = 1'b1;
            end
            ook48_pkg::OP_TICK: begin
                n_phase = phase_inc;
                if (r_sending) begin
                    n_elapsed = elapsed_inc;
                    if ({1'b0, elapsed_inc} == slot_end) begin
                        n_slot  = slot_inc;
                        started = 1'b1;
                        if (slot_inc < ook48_pkg::LastSlot) begin
                            n_key   = r_shift[ook48_pkg::SymW-1];
                            n_shift = {r_shift[ook48_pkg::SymW-2:0], 1'b0};
                        end else begin
                            n_key     = 1'b0;
                            n_sending = 1'b0;
                        end
                    end
                end else if (at_boundary && r_pend_valid) begin
                    n_pend_valid = 1'b0;
                    n_sending    = 1'b1;
                    n_elapsed    = '0;
                    n_slot       = '0;
                    n_key        = r_pend_sym[ook48_pkg::SymW-1];
                    n_shift      = {r_pend_sym[ook48_pkg::SymW-2:0], 1'b0};
                    started      = 1'b1;
                    taken        = 1'b1;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Hold configuration and keyer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_advance    <= ook48_pkg::AdvanceReset;
            r_phase      <= '0;
            r_sending    <= 1'b0;
            r_slot       <= '0;
            r_elapsed    <= '0;
            r_shift      <= '0;
            r_pend_valid <= 1'b0;
            r_pend_sym   <= '0;
            r_key        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_advance <= i_cfg_wr_data;
            end
            if (i_step.valid) begin
                r_phase      <= n_phase;
                r_sending    <= n_sending;
                r_slot       <= n_slot;
                r_elapsed    <= n_elapsed;
                r_shift      <= n_shift;
                r_pend_valid <= n_pend_valid;
                r_pend_sym   <= n_pend_sym;
                r_key        <= n_key;
            end
        end
    end

    // Result of this request
    assign o_result.key_on      = n_key;
    assign o_result.slot_start  = started;
    assign o_result.slot_number = n_slot;
    assign o_result.char_taken  = taken;

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_slot < ook48_pkg::LastSlot))
        else $error("slot counter past last data slot while sending");

    a_key_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> !r_key)
        else $error("key on while not sending");

    a_take_starts_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && taken) |-> (started && n_slot == '0))
        else $error("symbol taken without starting slot zero");

    a_take_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.valid && taken) |=> (!r_pend_valid && r_sending))
        else $error("pending symbol not consumed on take");

    a_send_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sending) |-> $past(r_pend_valid))
        else $error("sending began with nothing pending");

endmodule

FILE: hw/rtl/ook_four_of_eight_keyer.sv
// Channel   Dir  Bus             Contents
// request   in   s_axis_*        tdata = char_code, tuser = opcode (0 tick, 1 load)
// result    out  m_axis_*        tdata = key_on, slot_start, slot_number, char_taken
// config    in   i_cfg_wr_*      time_advance_ms, written when i_cfg_wr_en is high
//
// One request per cycle sustained while m_axis_tready stays high; a result reaches
// m_axis after its request passes the input register and then the result register,
// which is loaded from the keyer update.
// Reset is synchronous on i_rst_n low: advance returns to 225 ms, key off,
// nothing pending. A stalled m_axis_tready holds the result register and the
// input register; s_axis_tready drops only when both are full and m_axis_tready
// is low.
module ook_four_of_eight_keyer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
    input  logic                          s_axis_tuser,   // [0] opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] key_on, [1] slot_start, [5:2] slot_number, [6] char_taken, [7] zero
    output logic [7:0]                    m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic [ook48_pkg::AdvW-1:0]    i_cfg_wr_data
);

    logic                         r_in_valid;
    ook48_pkg::t_opcode           r_in_op;
    logic [ook48_pkg::CharW-1:0]  r_in_char;
    logic                         r_out_valid;
    ook48_pkg::t_result           r_out;
    logic                         advance;
    logic [ook48_pkg::SymW-1:0]   symbol;
    ook48_pkg::t_step_ctl         step;
    ook48_pkg::t_result           result;

    // Move when the result register is free or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= ook48_pkg::t_opcode'(s_axis_tuser);
            r_in_char <= s_axis_tdata;
        end
    end

    ook48_char_map u_char_map (
        .i_char_code (r_in_char),
        .o_symbol    (symbol)
    );

    assign step.valid  = r_in_valid && advance;
    assign step.opcode = r_in_op;

    ook48_keyer_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_symbol      (symbol),
        .o_result      (result)
    );

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.valid) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.char_taken, r_out.slot_number,
                            r_out.slot_start, r_out.key_on};

endmodule

FILE: sim/ook_four_of_eight_keyer_tb.sv
`timescale 1ns / 100ps

module ook_four_of_eight_keyer_tb;

    // Pending request, as it travels on the slave side
    typedef struct packed {
        ook48_pkg::t_opcode opcode;
        logic [7:0]         char_code;
    } t_request;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = '0;   // [7:0] char_code
    logic       s_axis_tuser   = 1'b0; // [0] opcode
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    // [0] key_on, [1] slot_start, [5:2] slot_number, [6] char_taken, [7] zero
    logic [7:0] m_axis_tdata;
    logic       i_cfg_wr_en    = 1'b0;
    logic [ook48_pkg::AdvW-1:0] i_cfg_wr_data = '0;

    ook_four_of_eight_keyer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Request stream and expected keyer outputs
    t_request           request_q[$];
    ook48_pkg::t_result keyer_out_q[$];

    // Keyer state as tracked by the testbench
    int         advance_ms = int'(ook48_pkg::AdvanceReset);
    int         ms_phase   = 0;
    bit         sending    = 1'b0;
    int         slot_cnt   = 0;
    int         elapsed    = 0;
    logic [7:0] shift_pat  = '0;
    bit         pend_valid = 1'b0;
    logic [7:0] pend_sym   = '0;
    bit         key        = 1'b0;

    int error_count   = 0;
    int tick_count    = 0;
    int load_count    = 0;
    int symbols_keyed = 0;
    int slot_starts   = 0;
    int results_seen  = 0;

    // Side pacing
    int tx_hold = 0;
    int rx_hold = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b1;

    function automatic int symbol_index(input logic [7:0] ch);
        if (ch == ook48_pkg::CharLf || ch == ook48_pkg::CharCr)
            return int'(ook48_pkg::CrLfIndex);
        if (ch >= ook48_pkg::UpperFirst && ch <= ook48_pkg::UpperLast)
            return int'(ch) - int'(ook48_pkg::UpperBias);
        if (ch >= ook48_pkg::LowerFirst && ch <= ook48_pkg::LowerLast)
            return int'(ch) - int'(ook48_pkg::LowerBias);
        return int'(ook48_pkg::NullIndex);
    endfunction

    // Apply one accepted request to the tracked state and queue its result
    task automatic advance_keyer(input ook48_pkg::t_opcode op, input logic [7:0] ch);
        ook48_pkg::t_result r;
        r = '0;
        if (op == ook48_pkg::OP_LOAD) begin
            pend_sym   = ook48_pkg::SymTable[symbol_index(ch)];
            pend_valid = 1'b1;
            load_count++;
        end else begin
            tick_count++;
            ms_phase = (ms_phase + 1) % int'(ook48_pkg::SecondMs);
            if (sending) begin
                elapsed = (elapsed + 1) % 1024;
                if (elapsed == int'(ook48_pkg::SlotMs) * (slot_cnt + 1)) begin
                    slot_cnt     = (slot_cnt + 1) % 16;
                    r.slot_start = 1'b1;
                    slot_starts++;
                    if (slot_cnt < int'(ook48_pkg::LastSlot)) begin
                        key       = shift_pat[7];
                        shift_pat = {shift_pat[6:0], 1'b0};
                    end else begin
                        key     = 1'b0;
                        sending = 1'b0;
                    end
                end
            end else if ((ms_phase + advance_ms) % int'(ook48_pkg::SecondMs) == 0
                         && pend_valid) begin
                shift_pat    = pend_sym;
                pend_valid   = 1'b0;
                sending      = 1'b1;
                elapsed      = 0;
                slot_cnt     = 0;
                key          = shift_pat[7];
                shift_pat    = {shift_pat[6:0], 1'b0};
                r.slot_start = 1'b1;
                r.char_taken = 1'b1;
                symbols_keyed++;
                slot_starts++;
            end
        end
        r.key_on      = key;
        r.slot_number = slot_cnt[ook48_pkg::SlotW-1:0];
        keyer_out_q.push_back(r);
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Driver: present queued requests, idle between them at random
    always @(posedge i_clk) begin
        logic     next_valid;
        t_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                advance_keyer(ook48_pkg::t_opcode'(s_axis_tuser), s_axis_tdata);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (tx_hold > 0) begin
                    tx_hold--;
                end else if (request_q.size() > 0) begin
                    req = request_q.pop_front();
                    s_axis_tdata <= req.char_code;
                    s_axis_tuser <= req.opcode;
                    next_valid = 1'b1;
                    if ($urandom_range(0, 40) == 0) tx_calm = !tx_calm;
                    tx_hold = tx_calm ? 0 : $urandom_range(0, 6);
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        ook48_pkg::t_result want;
        ook48_pkg::t_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got = ook48_pkg::t_result'(m_axis_tdata[6:0]);
                if (keyer_out_q.size() == 0) begin
                    flag_error($sformatf("unexpected result tdata=%02h", m_axis_tdata));
                end else begin
                    want = keyer_out_q.pop_front();
                    if (got !== want || m_axis_tdata[7] !== 1'b0) begin
                        flag_error($sformatf(
                            {"result %0d: expected key=%0b start=%0b slot=%0d taken=%0b,",
                             " got key=%0b start=%0b slot=%0d taken=%0b pad=%0b"},
                            results_seen, want.key_on, want.slot_start, want.slot_number,
                            want.char_taken, got.key_on, got.slot_start, got.slot_number,
                            got.char_taken, m_axis_tdata[7]));
                    end
                end
                if ($urandom_range(0, 40) == 0) rx_calm = !rx_calm;
                rx_hold = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] pick_char();
        logic [7:0] edges [7] = '{8'd10, 8'd13, 8'd31, 8'd96, 8'd123, 8'd0, 8'd255};
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(ook48_pkg::UpperFirst, ook48_pkg::UpperLast));
            2: return 8'($urandom_range(ook48_pkg::LowerFirst, ook48_pkg::LowerLast));
            default: return edges[$urandom_range(0, 6)];
        endcase
    endfunction

    task automatic push_request(input ook48_pkg::t_opcode op, input logic [7:0] ch);
        t_request req;
        req.opcode    = op;
        req.char_code = ch;
        request_q.push_back(req);
    endtask

    // Queue n requests, mostly ticks, with loads at the given percentage
    task automatic push_mixed(input int n, input int load_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < load_pct)
                push_request(ook48_pkg::OP_LOAD, pick_char());
            else
                push_request(ook48_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // Wait until every request is taken and every result checked
    task automatic drain();
        while (request_q.size() != 0 || s_axis_tvalid || keyer_out_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_advance(input int value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ook48_pkg::AdvW'(value);
        advance_ms = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Pick an advance that puts the next second boundary d ticks away
    task automatic aim_boundary(input int d);
        int adv;
        adv = (3000 - ms_phase - d) % 1000;
        if (adv < 24 && $urandom_range(0, 1) == 1) adv += 1000;
        write_advance(adv);
    endtask

    initial begin
        logic [7:0] directed_chars [14];
        directed_chars = '{8'd10, 8'd13, 8'd9, 8'd14, 8'd31, 8'd32, 8'd95,
                           8'd96, 8'd97, 8'd122, 8'd123, 8'd0, 8'd255, 8'd200};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: boundary on the first tick with nothing pending, then
        // every character class and its edges
        write_advance(int'(ook48_pkg::SecondLast));
        push_request(ook48_pkg::OP_TICK, 8'h00);
        foreach (directed_chars[i]) push_request(ook48_pkg::OP_LOAD, directed_chars[i]);
        push_request(ook48_pkg::OP_TICK, 8'hff);
        push_request(ook48_pkg::OP_TICK, 8'h5a);
        drain();

        // Zero advance, noisy mix of loads and ticks
        write_advance(0);
        push_mixed(60, 40);
        drain();

        // Start a symbol a few ticks ahead and key part of it
        aim_boundary($urandom_range(1, 8));
        push_request(ook48_pkg::OP_LOAD, pick_char());
        push_mixed(380, 3);
        drain();

        // Move the boundary under the running symbol, then run it out
        aim_boundary($urandom_range(1, 30));
        push_mixed(600, 3);
        drain();

        // Advance above the top of the range
        write_advance(1023);
        push_mixed(60, 30);
        drain();

        // One more symbol, cut off part way
        aim_boundary($urandom_range(1, 20));
        push_request(ook48_pkg::OP_LOAD, pick_char());
        push_mixed(200, 5);
        drain();

        repeat (8) @(posedge i_clk);
        if (keyer_out_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", keyer_out_q.size()));

        $display("Run covered %0d ticks and %0d loads, %0d results checked.",
                 tick_count, load_count, results_seen);
        $display("Keyed %0d symbols with %0d slot starts, %0d errors.",
                 symbols_keyed, slot_starts, error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
